[sv/pvbc_pkg.sv]
package pvbc_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_BAND_LEFT  = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_BAND_RIGHT = 1'd1;

	typedef enum logic [1:0] {
		CLS_LEFT  = 2'd0,
		CLS_MID   = 2'd1,
		CLS_RIGHT = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETUP,
		ST_DIV,
		ST_ROUND,
		ST_PUSH
	} state_t;

endpackage

[sv/polygon_vertical_band_clipper.sv]
// Clips a closed polygon to the band left <= x < right, one vertex word at a time.
// Slave stream: s_tdata carries vertex_x and vertex_y, s_tlast marks the last vertex.
// Master stream: m_tdata carries point_x and point_y, m_tuser is point_valid, m_tlast
// marks the final point of the clipped polygon. A closing step with no point gives one
// word with point_valid 0, zero coordinates and m_tlast high.
// Band bounds come through the cfg port (index 0 left, index 1 right); they are put in
// ascending order internally.
// One vertex is taken at a time. Each vertex walks six candidate slots (start vertex and
// two cuts for the incoming edge and for the closing edge); a start vertex is pushed
// directly, while a cut is formed by the bit-serial multiply-divide that computes y,
// one bit of |y1-y0| per cycle. No new vertex word is taken until the walk is done.
// Reset empties the output register, closes any open polygon, and sets the band to
// [0, 1.0). A stalled receiver holds the current output word; the sequencer waits
// with its next point until the output register drains, and s_tready stays low.
module polygon_vertical_band_clipper #(
	parameter int COORD_BITS = pvbc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pvbc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                       cfg_we,
	input  logic [pvbc_pkg::REG_IDX_BITS-1:0]         cfg_index,
	input  logic [COORD_BITS-1:0]                      cfg_data,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// vertex_x, vertex_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_tdata,
	input  logic                                       s_tlast,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// point_x, point_y, zero fill
	output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
	// point_valid
	output logic                                       m_tuser,
	output logic                                       m_tlast
);
	import pvbc_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int W      = COORD_BITS + 1;
	localparam int CNT_W  = $clog2(W);
	localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;
	localparam logic [CB-1:0] RIGHT_RESET = CB'(64'd1 << FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

	function automatic cls_t classify(input logic signed [CB-1:0] x,
			input logic signed [CB-1:0] lo, input logic signed [CB-1:0] hi);
		cls_t c;
		if (x < lo) c = CLS_LEFT;
		else if (x < hi) c = CLS_MID;
		else c = CLS_RIGHT;
		return c;
	endfunction

	state_t state_q, state_d;

	logic signed [CB-1:0] band_left_q, band_right_q, lo, hi;
	logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic have_first_q, last_q, mark_q;
	logic [2:0] slot_q;
	logic [5:0] mask_q;
	logic [1:0] hf_q;

	logic signed [CB-1:0] xb_q, y0_q;
	logic [W-1:0] a_q, b_q, d_q, r_q, q_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [CB-1:0] pt_x_q, pt_y_q;
	logic pt_valid_q, pt_last_q;

	logic m_tvalid_q, m_tuser_q, m_tlast_q;
	logic signed [CB-1:0] m_x_q, m_y_q;

	// handshake and control strobes
	logic accept, push_ok, do_push;

	// ------------------------------------------------------------------
	// band bounds in ascending order
	always_comb begin
		if (band_right_q < band_left_q) begin
			lo = band_right_q;
			hi = band_left_q;
		end else begin
			lo = band_left_q;
			hi = band_right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_left_q  <= '0;
			band_right_q <= RIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_LEFT:  band_left_q  <= cfg_data;
				REG_BAND_RIGHT: band_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// slot mask built when a vertex arrives
	logic signed [CB-1:0] in_x, in_y, fx;
	cls_t c_prev, c_cur, c_first;
	logic [2:0] e1_v, e2_v;
	logic e1_hf, e2_hf;
	logic [5:0] mask_new;

	assign in_x = s_tdata[CB-1:0];
	assign in_y = s_tdata[2*CB-1:CB];
	assign fx   = have_first_q ? first_x_q : in_x;

	always_comb begin
		c_prev  = classify(prev_x_q, lo, hi);
		c_cur   = classify(in_x, lo, hi);
		c_first = classify(fx, lo, hi);

		e1_hf   = c_prev > c_cur;
		e1_v[0] = have_first_q && (c_prev == CLS_MID);
		e1_v[1] = have_first_q && (c_prev != c_cur)
			&& (e1_hf ? (c_prev == CLS_RIGHT) : (c_prev == CLS_LEFT));
		e1_v[2] = have_first_q && (c_prev != c_cur)
			&& (e1_hf ? (c_cur == CLS_LEFT) : (c_cur == CLS_RIGHT));

		e2_hf   = c_cur > c_first;
		e2_v[0] = s_tlast && (c_cur == CLS_MID);
		e2_v[1] = s_tlast && (c_cur != c_first)
			&& (e2_hf ? (c_cur == CLS_RIGHT) : (c_cur == CLS_LEFT));
		e2_v[2] = s_tlast && (c_cur != c_first)
			&& (e2_hf ? (c_first == CLS_LEFT) : (c_first == CLS_RIGHT));

		mask_new = {e2_v, e1_v};
	end

	// ------------------------------------------------------------------
	// current slot decode
	logic       edge_sel, slot_on, slots_done, use_hi;
	logic [1:0] kind;
	logic [5:0] later;

	always_comb begin
		slots_done = slot_q >= 3'd6;
		edge_sel   = slot_q >= 3'd3;
		kind       = edge_sel ? 2'(slot_q - 3'd3) : slot_q[1:0];
		slot_on    = !slots_done && mask_q[slot_q];
		later      = mask_q >> ({1'b0, slot_q} + 4'd1);
		use_hi     = (kind == 2'd1) ? hf_q[edge_sel] : !hf_q[edge_sel];
	end

	logic signed [CB-1:0] x0, y0, x1, y1, xb;
	assign x0 = edge_sel ? cur_x_q   : prev_x_q;
	assign y0 = edge_sel ? cur_y_q   : prev_y_q;
	assign x1 = edge_sel ? first_x_q : cur_x_q;
	assign y1 = edge_sel ? first_y_q : cur_y_q;
	assign xb = use_hi ? hi : lo;

	// operand magnitudes; edge direction is known from the class order
	logic signed [W-1:0] x0w, x1w, xbw, y0w, y1w, bd;
	logic [W-1:0] a_new, d_new, b_new;
	logic fwd;

	always_comb begin
		x0w   = {x0[CB-1], x0};
		x1w   = {x1[CB-1], x1};
		xbw   = {xb[CB-1], xb};
		y0w   = {y0[CB-1], y0};
		y1w   = {y1[CB-1], y1};
		fwd   = !hf_q[edge_sel];
		a_new = fwd ? W'(xbw - x0w) : W'(x0w - xbw);
		d_new = fwd ? W'(x1w - x0w) : W'(x0w - x1w);
		bd    = y1w - y0w;
		b_new = bd[W-1] ? W'(-bd) : W'(bd);
	end

	// one bit of |dy| per cycle: r = 2r + bit*a, then take off d or 2d
	logic [W+1:0] t_sum, t_d1, t_d2, t_rem;
	logic [1:0] qd;
	logic [W-1:0] q_step;

	always_comb begin
		t_sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		t_d1  = {2'b00, d_q};
		t_d2  = {1'b0, d_q, 1'b0};
		if (t_sum >= t_d2) begin
			t_rem = t_sum - t_d2;
			qd    = 2'd2;
		end else if (t_sum >= t_d1) begin
			t_rem = t_sum - t_d1;
			qd    = 2'd1;
		end else begin
			t_rem = t_sum;
			qd    = 2'd0;
		end
		q_step = {q_q[W-2:0] + (W-1)'(qd[1]), qd[0]};
	end

	// round half away from zero folded into the carry-in of the final add
	logic inc;
	logic [W:0] y_sum;

	always_comb begin
		inc   = {r_q, 1'b0} >= {1'b0, d_q};
		y_sum = {{2{y0_q[CB-1]}}, y0_q}
			+ (neg_q ? ~{1'b0, q_q} : {1'b0, q_q})
			+ (W+1)'(neg_q ? !inc : inc);
	end

	// ------------------------------------------------------------------
	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SCAN;
			ST_SCAN: begin
				if (slots_done) state_d = mark_q ? ST_PUSH : ST_IDLE;
				else if (slot_on) state_d = (kind == 2'd0) ? ST_PUSH : ST_SETUP;
			end
			ST_SETUP: state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_PUSH;
			ST_PUSH:  if (push_ok) state_d = ST_SCAN;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = state_q == ST_IDLE;
		accept   = s_tvalid && s_tready;
		push_ok  = !m_tvalid_q || m_tready;
		do_push  = (state_q == ST_PUSH) && push_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_first_q <= 1'b0;
			slot_q       <= '0;
			mask_q       <= '0;
			hf_q         <= '0;
			last_q       <= 1'b0;
			mark_q       <= 1'b0;
			cnt_q        <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_x_q      <= in_x;
						cur_y_q      <= in_y;
						if (!have_first_q) begin
							first_x_q <= in_x;
							first_y_q <= in_y;
							prev_x_q  <= in_x;
							prev_y_q  <= in_y;
						end
						have_first_q <= !s_tlast;
						last_q       <= s_tlast;
						mask_q       <= mask_new;
						hf_q         <= {e2_hf, e1_hf};
						mark_q       <= s_tlast && (mask_new == '0);
						slot_q       <= '0;
					end
				end
				ST_SCAN: begin
					if (slots_done) begin
						if (mark_q) begin
							mark_q <= 1'b0;
						end else begin
							// edge is done: the vertex becomes the previous one
							prev_x_q <= cur_x_q;
							prev_y_q <= cur_y_q;
						end
					end else if (!slot_on) begin
						slot_q <= slot_q + 3'd1;
					end
				end
				ST_SETUP: cnt_q <= CNT_LAST;
				ST_DIV:   cnt_q <= cnt_q - CNT_W'(1);
				ST_PUSH:  if (push_ok) slot_q <= slot_q + 3'd1;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SCAN: begin
				if (slots_done) begin
					pt_x_q     <= '0;
					pt_y_q     <= '0;
					pt_valid_q <= 1'b0;
					pt_last_q  <= 1'b1;
				end else begin
					pt_x_q     <= x0;
					pt_y_q     <= y0;
					pt_valid_q <= 1'b1;
					pt_last_q  <= last_q && (later == '0);
				end
			end
			ST_SETUP: begin
				xb_q   <= xb;
				y0_q   <= y0;
				a_q    <= a_new;
				b_q    <= b_new;
				d_q    <= d_new;
				neg_q  <= bd[W-1];
				r_q    <= '0;
				q_q    <= '0;
			end
			ST_DIV: begin
				b_q <= {b_q[W-2:0], 1'b0};
				r_q <= t_rem[W-1:0];
				q_q <= q_step;
			end
			ST_ROUND: begin
				pt_x_q <= xb_q;
				pt_y_q <= y_sum[CB-1:0];
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (do_push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			m_x_q     <= pt_x_q;
			m_y_q     <= pt_y_q;
			m_tuser_q <= pt_valid_q;
			m_tlast_q <= pt_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'({m_y_q, m_x_q});
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// ------------------------------------------------------------------
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("end marker without last flag or with nonzero point");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r_q < d_q)
		else $error("divider remainder not below divisor");

	a_mark_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mark_q)
		else $error("end marker left pending at idle");

	a_no_early_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_SCAN && slot_q == '0)
		else $error("vertex walk did not start at the first slot");

endmodule
